### design/ffra_pkg.sv
// Package for the first-fit region allocator: payload structs, status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package ffra_pkg;

  localparam int unsigned FieldAddrBits = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic                     command;
    logic [FieldAddrBits-1:0] request_size;
    logic [FieldAddrBits-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [FieldAddrBits-1:0] payload_address;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_DONE
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the input item, clear the scan index
    logic scan_step;  // evaluate one gap or entry, advance index
    logic shift_up;   // move one entry up toward the insert slot
    logic place;      // write the new extent at the insert slot
    logic shift_dn;   // move one entry down over the freed slot
    logic count_inc;
    logic count_dec;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic free_zero;
    logic full;
    logic hit;        // current scan point fits / matches
    logic scan_last;  // current scan point is the last one
    logic shift_last; // the shift step now issued is the last one
  } dp_status_t;

endpackage

### design/ffra_ctrl.sv
// Controller state machine of the first-fit region allocator.
// Depends on ffra_pkg.
module ffra_ctrl
  import ffra_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_fire,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd,
  output logic       busy,
  output logic       set_result,
  output status_t    result_status
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (dp_status.is_free) begin
          if (dp_status.free_zero) state_nxt = S_DONE;
          else if (dp_status.hit) state_nxt = dp_status.shift_last ? S_DONE : S_SHIFT_DN;
          else if (dp_status.scan_last) state_nxt = S_DONE;
        end else begin
          if (dp_status.full) state_nxt = S_DONE;
          else if (dp_status.hit) state_nxt = dp_status.shift_last ? S_DONE : S_SHIFT_UP;
          else if (dp_status.scan_last) state_nxt = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        if (dp_status.shift_last) state_nxt = S_DONE;
      end
      S_SHIFT_DN: begin
        if (dp_status.shift_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    dp_cmd        = '0;
    set_result    = 1'b0;
    result_status = ST_OK;
    busy          = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        dp_cmd.load = in_fire;
      end
      S_SCAN: begin
        if (dp_status.is_free) begin
          if (dp_status.free_zero) begin
            set_result = 1'b1;
          end else if (dp_status.hit) begin
            set_result       = dp_status.shift_last;
            dp_cmd.count_dec = 1'b1;
          end else if (dp_status.scan_last) begin
            set_result    = 1'b1;
            result_status = ST_UNKNOWN;
          end else begin
            dp_cmd.scan_step = 1'b1;
          end
        end else begin
          if (dp_status.full) begin
            set_result    = 1'b1;
            result_status = ST_FULL;
          end else if (dp_status.hit) begin
            dp_cmd.count_inc = 1'b1;
            if (dp_status.shift_last) begin
              dp_cmd.place = 1'b1;
              set_result   = 1'b1;
            end
          end else if (dp_status.scan_last) begin
            set_result    = 1'b1;
            result_status = ST_NOFIT;
          end else begin
            dp_cmd.scan_step = 1'b1;
          end
        end
      end
      S_SHIFT_UP: begin
        dp_cmd.shift_up = 1'b1;
        if (dp_status.shift_last) begin
          dp_cmd.place = 1'b1;
          set_result   = 1'b1;
        end
      end
      S_SHIFT_DN: begin
        dp_cmd.shift_dn = 1'b1;
        set_result      = dp_status.shift_last;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### design/ffra_dp.sv
// Datapath of the first-fit region allocator: extent table, count, scan
// index and gap arithmetic. Depends on ffra_pkg.
module ffra_dp
  import ffra_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS  = 16,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned BASE_OFFSET  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  in_item_t                 in_item,
  input  logic [16:0]              region_size,
  input  dp_cmd_t                  dp_cmd,
  output dp_status_t               dp_status,
  output logic [FieldAddrBits-1:0] alloc_address
);

  localparam int unsigned ADDR_BITS = FieldAddrBits;
  localparam int unsigned IdxBits = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CntBits = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned WBits   = ADDR_BITS + 2;
  localparam logic [WBits-1:0] Cap    = WBits'(1) << ADDR_BITS;
  localparam logic [WBits-1:0] Hdr    = WBits'(HEADER_BYTES);
  localparam logic [WBits-1:0] Base   = WBits'(BASE_OFFSET);
  localparam logic [CntBits-1:0] MaxN = CntBits'(MAX_EXTENTS);

  logic [ADDR_BITS-1:0] start_mem [MAX_EXTENTS];
  logic [ADDR_BITS-1:0] size_mem  [MAX_EXTENTS];

  logic [CntBits-1:0]   count_r;
  logic [CntBits-1:0]   idx_r;     // scan index k, later shift pointer
  logic [WBits-1:0]     lo_r;      // end of previous extent
  logic                 cmd_r;
  logic [ADDR_BITS-1:0] req_r;
  logic [ADDR_BITS-1:0] faddr_r;
  logic [CntBits-1:0]   slot_r;    // insert/remove slot
  logic [ADDR_BITS-1:0] cur_start;
  logic [ADDR_BITS-1:0] cur_size;
  logic [IdxBits-1:0]   rd_idx;
  logic [WBits-1:0]     limit;
  logic [WBits-1:0]     hi;
  logic [WBits-1:0]     total;
  logic                 fits;
  logic                 match;
  logic                 scan_last;
  logic [WBits-1:0]     reg_w;

  // entry at the scan point (only read below count)
  assign rd_idx    = idx_r[IdxBits-1:0];
  assign cur_start = start_mem[rd_idx];
  assign cur_size  = size_mem[rd_idx];

  assign reg_w = WBits'(region_size);
  assign limit = (reg_w < Cap) ? reg_w : Cap;
  assign hi    = (idx_r < count_r) ? WBits'(cur_start) : limit;
  assign total = Hdr + WBits'(req_r);
  assign fits  = (hi > lo_r) && ((hi - lo_r) >= total) && ((lo_r + Hdr) < Cap);
  assign match = (idx_r < count_r) && ((WBits'(cur_start) + Hdr) == WBits'(faddr_r));
  assign scan_last = cmd_r ? (idx_r + 1'b1 >= count_r) : (idx_r >= count_r);

  always_comb begin
    dp_status.is_free   = cmd_r;
    dp_status.free_zero = (faddr_r == '0);
    dp_status.full      = (count_r >= MaxN);
    dp_status.hit       = cmd_r ? match : fits;
    dp_status.scan_last = scan_last;
    // in SCAN: last when no entries move; shifting up: pointer just above slot;
    // shifting down: pointer at last live entry (count already holds the decremented value)
    if (dp_cmd.shift_up) dp_status.shift_last = (idx_r == slot_r + 1'b1);
    else if (dp_cmd.shift_dn) dp_status.shift_last = (idx_r + 1'b1 >= count_r);
    else if (cmd_r) dp_status.shift_last = (idx_r + 1'b1 >= count_r);
    else dp_status.shift_last = (idx_r == count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (dp_cmd.count_inc) begin
      count_r <= count_r + 1'b1;
    end else if (dp_cmd.count_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r   <= in_item.command;
      req_r   <= in_item.request_size;
      faddr_r <= in_item.free_address;
      idx_r   <= '0;
      lo_r    <= Base;
    end else if (dp_cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      lo_r  <= WBits'(cur_start) + Hdr + WBits'(cur_size);
    end else if (dp_cmd.count_inc) begin
      // start moving down from the top: copy count-1 -> count first
      slot_r        <= idx_r;
      alloc_address <= ADDR_BITS'(lo_r + Hdr);
      idx_r         <= count_r;
    end else if (dp_cmd.count_dec) begin
      slot_r <= idx_r;
    end else if (dp_cmd.shift_up) begin
      idx_r <= idx_r - 1'b1;
    end else if (dp_cmd.shift_dn) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  logic [IdxBits-1:0] up_dst, up_src, dn_dst, dn_src, pl_idx;
  assign up_dst = idx_r[IdxBits-1:0];
  assign up_src = IdxBits'(idx_r - 1'b1);
  assign dn_dst = idx_r[IdxBits-1:0];
  assign dn_src = IdxBits'(idx_r + 1'b1);
  assign pl_idx = dp_cmd.shift_up ? IdxBits'(slot_r) : idx_r[IdxBits-1:0];

  // table writes: one shift move and/or the final placement per cycle
  always_ff @(posedge clk) begin
    if (dp_cmd.shift_up) begin
      start_mem[up_dst] <= start_mem[up_src];
      size_mem[up_dst]  <= size_mem[up_src];
    end else if (dp_cmd.shift_dn) begin
      start_mem[dn_dst] <= start_mem[dn_src];
      size_mem[dn_dst]  <= size_mem[dn_src];
    end
    if (dp_cmd.place) begin
      start_mem[pl_idx] <= ADDR_BITS'(lo_r);
      size_mem[pl_idx]  <= req_r;
    end
  end

endmodule

### design/first_fit_region_allocator_top.sv
// Top level of the first-fit region allocator.
// Depends on ffra_pkg, ffra_ctrl and ffra_dp.
//
// One transaction in, one transaction out. An allocate walks the table,
// examining each gap up to the first fit, then shifting each later entry up.
// A free walks the table, comparing each entry up to the match, then
// shifting each later entry down. A free of zero and an allocate into a full
// table end the walk at once. The walk covers the extent table one entry per
// cycle. When the walk ends, the result passes through the pend register into
// out_valid, and the next transaction is taken only after that result has
// been taken. The block handles one transaction at a time; the result
// register holds until taken. region_size is written by cfg_we/cfg_wdata;
// the user must write it only while the block is idle, as the block itself
// does not enforce this.
module first_fit_region_allocator_top
  import ffra_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS  = 16,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned BASE_OFFSET  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  logic [16:0]              region_size_r;
  logic                     busy;
  logic                     set_result;
  status_t                  result_status;
  dp_cmd_t                  dp_cmd;
  dp_status_t               dp_status;
  logic [FieldAddrBits-1:0] alloc_address;
  logic                     in_fire;
  logic                     out_fire;
  logic                     pend_r;
  status_t                  stat_r;
  logic                     alloc_ok_r;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_size_r <= 17'h10000;
    end else if (cfg_we) begin
      region_size_r <= cfg_wdata;
    end
  end

  // result register: the last walk step sets pend_r, which then raises valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (set_result) begin
        pend_r     <= 1'b1;
        stat_r     <= result_status;
        alloc_ok_r <= !dp_status.is_free && (result_status == ST_OK);
      end
      if (pend_r && !out_valid) begin
        out_valid <= 1'b1;
        pend_r    <= 1'b0;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data.status          = stat_r;
  assign out_data.payload_address = alloc_ok_r ? alloc_address : '0;

  ffra_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .out_fire      (out_fire),
    .dp_status     (dp_status),
    .dp_cmd        (dp_cmd),
    .busy          (busy),
    .set_result    (set_result),
    .result_status (result_status)
  );

  ffra_dp #(
    .MAX_EXTENTS  (MAX_EXTENTS),
    .HEADER_BYTES (HEADER_BYTES),
    .BASE_OFFSET  (BASE_OFFSET)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item       (in_data),
    .region_size   (region_size_r),
    .dp_cmd        (dp_cmd),
    .dp_status     (dp_status),
    .alloc_address (alloc_address)
  );

endmodule

### tb/testbench.sv
// Testbench for first_fit_region_allocator_top: directed table then random
// allocate/free traffic, checked against a behavioral allocator model.
// Depends on ffra_pkg and the design files.
`timescale 1ns / 100ps

module testbench;
  import ffra_pkg::*;

  localparam int unsigned MaxExtents  = 16;
  localparam int unsigned HeaderBytes = 32;
  localparam int unsigned BaseOffset  = 16;
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;
  localparam int unsigned CycleLimit = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  first_fit_region_allocator_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Allocator model state
  logic [16:0] model_region;
  int unsigned ext_start[MaxExtents];
  int unsigned ext_size[MaxExtents];
  int unsigned ext_count;

  out_item_t pending_results[$];
  int unsigned mismatches;
  int unsigned cycle_count;

  // Compute the result of one transaction and advance the model.
  function automatic out_item_t allocate_or_free(in_item_t it);
    out_item_t res;
    longint unsigned lo, hi, space, total, lim;
    int unsigned k, j, n;
    res.status = ST_OK;
    res.payload_address = '0;
    n = ext_count;
    if (it.command == CmdAlloc) begin
      if (n >= MaxExtents) begin
        res.status = ST_FULL;
        return res;
      end
      total = 64'(HeaderBytes) + 64'(it.request_size);
      lim = (model_region < 17'h10000) ? 64'(model_region) : 64'(65536);
      for (k = 0; k <= n; k++) begin
        lo = (k == 0) ? 64'(BaseOffset)
                      : 64'(ext_start[k-1]) + 64'(HeaderBytes) + 64'(ext_size[k-1]);
        hi = (k < n) ? 64'(ext_start[k]) : lim;
        space = (hi > lo) ? hi - lo : 0;
        if (space >= total && lo + HeaderBytes < 65536) begin
          for (j = n; j > k; j--) begin
            ext_start[j] = ext_start[j-1];
            ext_size[j] = ext_size[j-1];
          end
          ext_start[k] = 32'(lo);
          ext_size[k] = 32'(it.request_size);
          ext_count = n + 1;
          res.payload_address = 16'(lo + HeaderBytes);
          return res;
        end
      end
      res.status = ST_NOFIT;
    end else begin
      if (it.free_address == 0) return res;
      for (k = 0; k < n; k++) begin
        if (ext_start[k] + HeaderBytes == 32'(it.free_address)) begin
          for (j = k; j + 1 < n; j++) begin
            ext_start[j] = ext_start[j+1];
            ext_size[j] = ext_size[j+1];
          end
          ext_count = n - 1;
          return res;
        end
      end
      res.status = ST_UNKNOWN;
    end
    return res;
  endfunction

  // Directed rows; exp_known marks rows whose result is typed in.
  typedef struct {
    logic        cmd;
    logic [15:0] req;
    logic [15:0] addr;
    bit          exp_known;
    logic [1:0]  exp_status;
    logic [15:0] exp_addr;
  } row_t;

  row_t directed_rows[$] = '{
    '{CmdFree,  16'd0,     16'd0,     1, ST_OK,      16'd0},   // free of zero
    '{CmdFree,  16'd0,     16'hFFFF,  1, ST_UNKNOWN, 16'd0},   // empty table
    '{CmdAlloc, 16'd0,     16'd0,     1, ST_OK,      16'd48},  // first extent
    '{CmdAlloc, 16'hFFFF,  16'd0,     1, ST_NOFIT,   16'd0},   // too large
    '{CmdAlloc, 16'd100,   16'd0,     1, ST_OK,      16'd80},
    '{CmdFree,  16'd0,     16'd48,    1, ST_OK,      16'd0},
    '{CmdAlloc, 16'd0,     16'd0,     1, ST_OK,      16'd48},  // reuse first gap
    '{CmdFree,  16'hFFFF,  16'd49,    1, ST_UNKNOWN, 16'd0},
    '{CmdAlloc, 16'd65000, 16'd0,     0, ST_OK,      16'd0},
    '{CmdAlloc, 16'd300,   16'hFFFF,  0, ST_OK,      16'd0},
    '{CmdFree,  16'd0,     16'd80,    1, ST_OK,      16'd0},
    '{CmdAlloc, 16'd1,     16'd0,     0, ST_OK,      16'd0}
  };

  // Send one transaction: hold valid until accepted, then predict.
  task automatic send_item(in_item_t it, bit known, out_item_t typed);
    out_item_t pred;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = allocate_or_free(it);
    if (known) pred = typed;
    pending_results.push_back(pred);
    @(negedge clk);
    // Bursty sender: drop valid for a random gap now and then.
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2 * MaxExtents + 8) @(negedge clk);
  endtask

  task automatic write_region(logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_region = val;
  endtask

  // Random item: mostly allocs and frees of live extents.
  function automatic in_item_t random_item(int unsigned big_pct);
    in_item_t it;
    int unsigned sel;
    it.request_size = 16'($urandom);
    it.free_address = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      it.command = CmdAlloc;
      if ($urandom_range(0, 99) >= big_pct)
        it.request_size = 16'($urandom_range(0, 4000));
    end else begin
      it.command = CmdFree;
      if (sel < 90 && ext_count != 0)
        it.free_address = 16'(ext_start[$urandom_range(0, ext_count - 1)] + HeaderBytes);
      else if (sel < 93)
        it.free_address = '0;
    end
    return it;
  endfunction

  // Receiver: stall on its own pattern, check on each accepted result.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (cycle_count % 512 < 128) out_ready <= 1'b1;   // no-stall stretch
    else out_ready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    out_item_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result status=%0d addr=%0d",
                   out_data.status, out_data.payload_address);
      end else begin
        want = pending_results.pop_front();
        if (want.status !== out_data.status ||
            want.payload_address !== out_data.payload_address) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status=%0d addr=%0d, got status=%0d addr=%0d",
                     want.status, want.payload_address,
                     out_data.status, out_data.payload_address);
        end
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("[first_fit_region_allocator_top] ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    out_item_t typed;
    logic [16:0] regions[5];
    mismatches = 0;
    cycle_count = 0;
    model_region = 17'h10000;
    ext_count = 0;
    regions = '{17'h10000, 17'd16, 17'h1FFFF, 17'd600, 17'd3000};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset configuration.
    foreach (directed_rows[i]) begin
      it.command = directed_rows[i].cmd;
      it.request_size = directed_rows[i].req;
      it.free_address = directed_rows[i].addr;
      typed.status = directed_rows[i].exp_status;
      typed.payload_address = directed_rows[i].exp_addr;
      send_item(it, directed_rows[i].exp_known, typed);
    end
    // Fill the table to hit the full status.
    repeat (MaxExtents + 2) begin
      it = '0;
      it.command = CmdAlloc;
      it.request_size = 16'd8;
      send_item(it, 0, typed);
    end
    drain_and_idle();

    // Random phases across several region sizes, extremes included.
    foreach (regions[p]) begin
      write_region(regions[p]);
      for (int n = 0; n < 300; n++) begin
        it = random_item(10);
        send_item(it, 0, typed);
      end
      drain_and_idle();
    end
    // Shrink the region under live extents, then keep working.
    write_region(17'd200);
    for (int n = 0; n < 60; n++) begin
      it = random_item(5);
      send_item(it, 0, typed);
    end
    drain_and_idle();

    if (mismatches == 0) begin
      $display("[first_fit_region_allocator_top] OK");
    end else begin
      $display("[first_fit_region_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
